### design/arc_pose_step_and_lattice_index_macros.svh
// Assertion macros shared by the block.
`ifndef ARC_POSE_STEP_AND_LATTICE_INDEX_MACROS_SVH
`define ARC_POSE_STEP_AND_LATTICE_INDEX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APSLI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("apsli assertion failed");

// Next-cycle implication, checked during reset as well.
`define APSLI_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("apsli assertion failed");

`endif

### design/apsli_pkg.sv
`default_nettype none
package apsli_pkg;

   localparam int CORDIC_ITERS      = 24;
   localparam int HEADING_BINS_DEF  = 64;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [1:0] TURN_STRAIGHT = 2'd0;
   localparam logic [1:0] TURN_LEFT     = 2'd1;
   localparam logic [1:0] TURN_RIGHT    = 2'd2;

   localparam logic [2:0] CSR_STEP_LENGTH    = 3'd0;
   localparam logic [2:0] CSR_TURN_RADIUS    = 3'd1;
   localparam logic [2:0] CSR_ARC_ANGLE      = 3'd2;
   localparam logic [2:0] CSR_ORIGIN_X       = 3'd3;
   localparam logic [2:0] CSR_ORIGIN_Y       = 3'd4;
   localparam logic [2:0] CSR_INV_RESOLUTION = 3'd5;
   localparam logic [2:0] CSR_GRID_WIDTH     = 3'd6;
   localparam logic [2:0] CSR_GRID_HEIGHT    = 3'd7;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_vec_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [15:0]        nh;
      logic               arc;
      logic               flip0;
      logic               flip1;
      logic signed [31:0] mul_a;
   } side_type;

   function automatic logic signed [33:0] atan_entry(input int i);
      logic signed [33:0] r;
      begin
         case (i)
            0: r = 34'sd536870912;
            1: r = 34'sd316933406;
            2: r = 34'sd167458907;
            3: r = 34'sd85004756;
            4: r = 34'sd42667331;
            5: r = 34'sd21354465;
            6: r = 34'sd10679838;
            7: r = 34'sd5340245;
            8: r = 34'sd2670163;
            9: r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = 34'sd0;
         endcase
         return r;
      end
   endfunction

   // Angles in the second and third quadrant are folded by a half turn.
   function automatic logic heading_flip(input logic [15:0] h);
      return h[15] ^ h[14];
   endfunction

   function automatic cordic_vec_type cordic_init(input logic [15:0] h);
      cordic_vec_type v;
      logic [15:0] hz;
      begin
         hz = {h[15] ^ heading_flip(h), h[14:0]};
         v.x = CORDIC_GAIN;
         v.y = 34'sd0;
         v.z = signed'({{2{hz[15]}}, hz, 16'b0});
         return v;
      end
   endfunction

endpackage
`default_nettype wire

### design/apsli_cordic_cell.sv
`default_nettype none
module apsli_cordic_cell #(
   parameter int ITER = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     valid_in,
   input  apsli_pkg::cordic_vec_type a_in,
   input  apsli_pkg::cordic_vec_type b_in,
   input  apsli_pkg::side_type      side_in,
   output logic                     valid_out,
   output apsli_pkg::cordic_vec_type a_out,
   output apsli_pkg::cordic_vec_type b_out,
   output apsli_pkg::side_type      side_out
);
   import apsli_pkg::*;

   logic           valid_ff;
   cordic_vec_type a_ff, a_in_rot;
   cordic_vec_type b_ff, b_in_rot;
   side_type       side_ff;

   // One micro-rotation toward zero residual angle.
   function automatic cordic_vec_type rotate(input cordic_vec_type v);
      cordic_vec_type r;
      begin
         if (v.z >= 0) begin
            r.x = v.x - (v.y >>> ITER);
            r.y = v.y + (v.x >>> ITER);
            r.z = v.z - atan_entry(ITER);
         end else begin
            r.x = v.x + (v.y >>> ITER);
            r.y = v.y - (v.x >>> ITER);
            r.z = v.z + atan_entry(ITER);
         end
         return r;
      end
   endfunction

   always_comb begin
      a_in_rot = rotate(a_in);
      b_in_rot = rotate(b_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff    <= a_in_rot;
         b_ff    <= b_in_rot;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign a_out     = a_ff;
   assign b_out     = b_ff;
   assign side_out  = side_ff;
endmodule
`default_nettype wire

### design/apsli_grid_axis.sv
`default_nettype none
module apsli_grid_axis (
   input  logic               clock,
   input  logic               advance,
   input  logic signed [31:0] pos,
   input  logic signed [31:0] origin,
   input  logic [31:0]        inv_resolution,
   input  logic [12:0]        n_eff,
   output logic               in_grid,
   output logic [11:0]        cell_idx
);
   import apsli_pkg::*;

   logic signed [32:0] off;
   logic        neg_ff, neg_in;
   logic        empty_ff, empty_in;
   logic [11:0] last_ff, last_in;
   logic [47:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [63:0] scaled;
   logic [32:0] rounded;
   logic        inside_ff, inside_in;
   logic [11:0] cell_ff, cell_in;

   always_comb begin
      off      = 33'(pos) - 33'(origin);
      neg_in   = off[32];
      empty_in = (n_eff == 13'd0);
      last_in  = 12'(n_eff - 13'd1);
      plo_in   = 48'(off[15:0]) * 48'(inv_resolution);
      phi_in   = 48'(off[31:16]) * 48'(inv_resolution);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff   <= neg_in;
         empty_ff <= empty_in;
         last_ff  <= last_in;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
      end
   end

   // Scaled offset is Q32.32 cells; beyond the last cell is out of the grid.
   always_comb begin
      scaled    = {phi_ff, 16'b0} + 64'(plo_ff);
      inside_in = !neg_ff && !empty_ff &&
                  !((scaled[63:32] > 32'(last_ff)) ||
                    ((scaled[63:32] == 32'(last_ff)) && (scaled[31:0] != 32'd0)));
      rounded   = 33'((65'(scaled) + 65'h80000000) >> 32);
      if (rounded > 33'(last_ff)) begin
         cell_in = last_ff;
      end else begin
         cell_in = rounded[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inside_ff <= inside_in;
         cell_ff   <= cell_in;
      end
   end

   assign in_grid  = inside_ff;
   assign cell_idx = cell_ff;
endmodule
`default_nettype wire

### design/arc_pose_step_and_lattice_index.sv
// Pose stepper for a state lattice: one pose word in, one stepped pose word out.
// The req channel carries x, y and heading in tdata and the turn choice and
// the reverse flag in tuser. The rsp channel returns the new pose, the grid
// cell, the heading bin and the flat lattice index, with in_bounds in tuser.
// Registers are written over the csr channel, which is always ready; write
// them only while no word is in flight.
// From acceptance to rsp_tvalid a word passes one entry register, 24 CORDIC
// cells (two sine/cosine rotations side by side, one iteration per cell),
// four stages for the split product, rounding and saturation, two for the
// grid scaling per axis, one for the row product and the output register.
// Throughput is one word per cycle. The whole pipeline moves as one; when the
// receiver holds rsp_tready low with a word waiting, every stage and req_tready
// stall until the word is taken. Synchronous reset empties the pipeline and
// restores the register defaults.
`default_nettype none
`include "arc_pose_step_and_lattice_index_macros.svh"
module arc_pose_step_and_lattice_index #(
   parameter int HEADING_BINS = apsli_pkg::HEADING_BINS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // tdata: pose_x[31:0], pose_y[63:32], heading[79:64]
   input  logic [79:0]  req_tdata,
   // tuser: turn_select[1:0], reverse[2]
   input  logic [2:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: next_x[31:0], next_y[63:32], next_heading[79:64], cell_x[91:80],
   // cell_y[103:92], heading_bin[113:104], cell_index[147:114], zero pad
   output logic [151:0] rsp_tdata,
   // tuser: in_bounds[0]
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import apsli_pkg::*;

   // Configuration registers.
   logic [30:0]        step_length_ff;
   logic [30:0]        turn_radius_ff;
   logic [14:0]        arc_angle_ff;
   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [31:0]        inv_resolution_ff;
   logic [12:0]        grid_width_ff, grid_height_ff;
   logic [12:0]        w_eff, h_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_length_ff    <= 31'd65536;
         turn_radius_ff    <= 31'd327680;
         arc_angle_ff      <= 15'd2086;
         origin_x_ff       <= 32'sd0;
         origin_y_ff       <= 32'sd0;
         inv_resolution_ff <= 32'd655360;
         grid_width_ff     <= 13'd256;
         grid_height_ff    <= 13'd256;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STEP_LENGTH:    step_length_ff    <= csr_data[30:0];
            CSR_TURN_RADIUS:    turn_radius_ff    <= csr_data[30:0];
            CSR_ARC_ANGLE:      arc_angle_ff      <= csr_data[14:0];
            CSR_ORIGIN_X:       origin_x_ff       <= signed'(csr_data);
            CSR_ORIGIN_Y:       origin_y_ff       <= signed'(csr_data);
            CSR_INV_RESOLUTION: inv_resolution_ff <= csr_data;
            CSR_GRID_WIDTH:     grid_width_ff     <= csr_data[12:0];
            CSR_GRID_HEIGHT:    grid_height_ff    <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // Grids larger than 4096 cells act as 4096.
   assign w_eff = (grid_width_ff > 13'd4096) ? 13'd4096 : grid_width_ff;
   assign h_eff = (grid_height_ff > 13'd4096) ? 13'd4096 : grid_height_ff;

   // The whole pipeline advances together unless a finished word is stuck.
   logic advance;
   logic out_valid_ff;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Entry stage: new heading, CORDIC seeds and the signed multiplier operand.
   logic [15:0]        h;
   logic [1:0]         ts;
   logic               rev, arc, left;
   logic signed [31:0] radius_s, step_s;
   side_type           side_in;
   cordic_vec_type     ea_in, eb_in;
   logic               e_valid_ff;
   cordic_vec_type     ea_ff, eb_ff;
   side_type           e_side_ff;

   always_comb begin
      h        = req_tdata[79:64];
      ts       = req_tuser[1:0];
      rev      = req_tuser[2];
      arc      = (ts == TURN_LEFT) || (ts == TURN_RIGHT);
      left     = (ts == TURN_LEFT);
      radius_s = signed'({1'b0, turn_radius_ff});
      step_s   = signed'({1'b0, step_length_ff});
      side_in.px  = signed'(req_tdata[31:0]);
      side_in.py  = signed'(req_tdata[63:32]);
      side_in.arc = arc;
      if (!arc) begin
         side_in.nh = h;
      end else if (left != rev) begin
         side_in.nh = h + {1'b0, arc_angle_ff};
      end else begin
         side_in.nh = h - {1'b0, arc_angle_ff};
      end
      // A right turn negates the whole product, so the radius is negated here.
      if (arc) begin
         side_in.mul_a = left ? radius_s : -radius_s;
      end else begin
         side_in.mul_a = rev ? -step_s : step_s;
      end
      side_in.flip0 = heading_flip(h);
      side_in.flip1 = heading_flip(side_in.nh);
      ea_in = cordic_init(h);
      eb_in = cordic_init(side_in.nh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ea_ff     <= ea_in;
         eb_ff     <= eb_in;
         e_side_ff <= side_in;
      end
   end

   // Row of CORDIC cells, one iteration each, for the old and new heading.
   logic           cv [CORDIC_ITERS+1];
   cordic_vec_type ca [CORDIC_ITERS+1];
   cordic_vec_type cb [CORDIC_ITERS+1];
   side_type       cs [CORDIC_ITERS+1];

   assign cv[0] = e_valid_ff;
   assign ca[0] = ea_ff;
   assign cb[0] = eb_ff;
   assign cs[0] = e_side_ff;

   for (genvar gi = 0; gi < CORDIC_ITERS; gi++) begin : g_cell
      apsli_cordic_cell #(.ITER(gi)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (cv[gi]),
         .a_in      (ca[gi]),
         .b_in      (cb[gi]),
         .side_in   (cs[gi]),
         .valid_out (cv[gi+1]),
         .a_out     (ca[gi+1]),
         .b_out     (cb[gi+1]),
         .side_out  (cs[gi+1])
      );
   end

   // P1: undo the half-turn fold and form the multiplicands.
   cordic_vec_type     fa, fb;
   side_type           sd;
   logic signed [33:0] s0, c0, s1, c1;
   logic signed [33:0] bx_in, by_in;
   logic               p1_valid_ff;
   logic signed [33:0] bx_ff, by_ff;
   side_type           p1_side_ff;

   always_comb begin
      fa = ca[CORDIC_ITERS];
      fb = cb[CORDIC_ITERS];
      sd = cs[CORDIC_ITERS];
      s0 = sd.flip0 ? -fa.y : fa.y;
      c0 = sd.flip0 ? -fa.x : fa.x;
      s1 = sd.flip1 ? -fb.y : fb.y;
      c1 = sd.flip1 ? -fb.x : fb.x;
      bx_in = sd.arc ? (s1 - s0) : c0;
      by_in = sd.arc ? (c0 - c1) : s0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= cv[CORDIC_ITERS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bx_ff      <= bx_in;
         by_ff      <= by_in;
         p1_side_ff <= sd;
      end
   end

   // P2: the 32 by 34 product as two partial products on 17-bit halves.
   // The low half is taken as unsigned and the high half keeps the sign.
   logic signed [49:0] xlo_in, ylo_in, xlo_ff, ylo_ff;
   logic signed [48:0] xhi_in, yhi_in, xhi_ff, yhi_ff;
   logic               p2_valid_ff;
   side_type           p2_side_ff;

   always_comb begin
      xlo_in = p1_side_ff.mul_a * signed'({1'b0, bx_ff[16:0]});
      ylo_in = p1_side_ff.mul_a * signed'({1'b0, by_ff[16:0]});
      xhi_in = p1_side_ff.mul_a * signed'(bx_ff[33:17]);
      yhi_in = p1_side_ff.mul_a * signed'(by_ff[33:17]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xlo_ff     <= xlo_in;
         ylo_ff     <= ylo_in;
         xhi_ff     <= xhi_in;
         yhi_ff     <= yhi_in;
         p2_side_ff <= p1_side_ff;
      end
   end

   // P3: join the halves and round to Q16.16, half up.
   logic signed [65:0] px_prod, py_prod;
   logic signed [35:0] dx_in, dy_in, dx_ff, dy_ff;
   logic               p3_valid_ff;
   side_type           p3_side_ff;

   always_comb begin
      px_prod = (66'(xhi_ff) <<< 17) + 66'(xlo_ff);
      py_prod = (66'(yhi_ff) <<< 17) + 66'(ylo_ff);
      dx_in   = 36'((px_prod + 66'sd536870912) >>> 30);
      dy_in   = 36'((py_prod + 66'sd536870912) >>> 30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (advance) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         p3_side_ff <= p2_side_ff;
      end
   end

   // P4: move the pose and saturate to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      if (v > 37'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -37'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   logic signed [31:0] nx_in, ny_in, nx_ff, ny_ff;
   logic [15:0]        p4_nh_ff;
   logic               p4_valid_ff;

   always_comb begin
      nx_in = sat32(37'(p3_side_ff.px) + 37'(dx_ff));
      ny_in = sat32(37'(p3_side_ff.py) + 37'(dy_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (advance) begin
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         p4_nh_ff <= p3_side_ff.nh;
      end
   end

   // G1, G2: grid scaling per axis, pose data rides alongside.
   logic               gx_inside, gy_inside;
   logic [11:0]        gx_cell, gy_cell;
   logic               g1_valid_ff, g2_valid_ff;
   logic signed [31:0] g1_nx_ff, g1_ny_ff, g2_nx_ff, g2_ny_ff;
   logic [15:0]        g1_nh_ff, g2_nh_ff;

   apsli_grid_axis u_axis_x (
      .clock          (clock),
      .advance        (advance),
      .pos            (nx_ff),
      .origin         (origin_x_ff),
      .inv_resolution (inv_resolution_ff),
      .n_eff          (w_eff),
      .in_grid        (gx_inside),
      .cell_idx       (gx_cell)
   );

   apsli_grid_axis u_axis_y (
      .clock          (clock),
      .advance        (advance),
      .pos            (ny_ff),
      .origin         (origin_y_ff),
      .inv_resolution (inv_resolution_ff),
      .n_eff          (h_eff),
      .in_grid        (gy_inside),
      .cell_idx       (gy_cell)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_valid_ff <= 1'b0;
         g2_valid_ff <= 1'b0;
      end else if (advance) begin
         g1_valid_ff <= p4_valid_ff;
         g2_valid_ff <= g1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         g1_nx_ff <= nx_ff;
         g1_ny_ff <= ny_ff;
         g1_nh_ff <= p4_nh_ff;
         g2_nx_ff <= g1_nx_ff;
         g2_ny_ff <= g1_ny_ff;
         g2_nh_ff <= g1_nh_ff;
      end
   end

   // I1: heading bin and the row product.
   logic [9:0]         bin_in, bin_ff;
   logic [24:0]        row_in, row_ff;
   logic               inb_ff;
   logic [11:0]        i_cx_ff, i_cy_ff;
   logic signed [31:0] i_nx_ff, i_ny_ff;
   logic [15:0]        i_nh_ff;
   logic               i_valid_ff;

   always_comb begin
      bin_in = 10'((32'(g2_nh_ff) * 32'(HEADING_BINS)) >> 16);
      row_in = 25'(gy_cell) * 25'(w_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else if (advance) begin
         i_valid_ff <= g2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bin_ff  <= bin_in;
         row_ff  <= row_in;
         inb_ff  <= gx_inside && gy_inside;
         i_cx_ff <= gx_cell;
         i_cy_ff <= gy_cell;
         i_nx_ff <= g2_nx_ff;
         i_ny_ff <= g2_ny_ff;
         i_nh_ff <= g2_nh_ff;
      end
   end

   // Output register: flat index, and zeroed cell fields when out of the grid.
   logic [33:0]  index_in;
   logic [151:0] out_data_ff;
   logic         out_inb_ff;

   always_comb begin
      index_in = 34'((35'(row_ff) + 35'(i_cx_ff)) * 35'(HEADING_BINS) + 35'(bin_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= i_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {4'b0,
                         inb_ff ? index_in : 34'd0,
                         bin_ff,
                         inb_ff ? i_cy_ff : 12'd0,
                         inb_ff ? i_cx_ff : 12'd0,
                         i_nh_ff,
                         i_ny_ff,
                         i_nx_ff};
         out_inb_ff  <= inb_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_inb_ff;

   `APSLI_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)
   `APSLI_ASSERT_IMP(a_out_zero_fields, clock, reset,
      rsp_tvalid && !rsp_tuser[0],
      (rsp_tdata[147:114] == 34'd0) && (rsp_tdata[103:80] == 24'd0))
   `APSLI_ASSERT_IMP(a_cell_in_grid, clock, reset,
      rsp_tvalid && rsp_tuser[0],
      (13'(rsp_tdata[91:80]) < w_eff) && (13'(rsp_tdata[103:92]) < h_eff))
endmodule
`default_nettype wire
